FILE: sv/vsrt_pkg.sv
// Shared types, constants and address helpers of the video scroll register timing core.
package vsrt_pkg;

	localparam logic [8:0] VISIBLE_DOTS = 9'd256;
	localparam logic [8:0] LINE_END_DOT = 9'd340;
	localparam logic [8:0] VISIBLE_LINES = 9'd240;
	localparam logic [8:0] FRAME_END_LINE = 9'd261;
	localparam logic [8:0] VCOPY_FIRST_DOT = 9'd280;
	localparam logic [8:0] VCOPY_LAST_DOT = 9'd304;

	localparam logic [14:0] HCOPY_MASK = 15'h041f;
	localparam logic [14:0] VCOPY_MASK = 15'h7be0;
	localparam logic [14:0] PALETTE_BASE = 15'h3f00;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_CTRL_WR = 3'd1;
	localparam logic [2:0] OP_MASK_WR = 3'd2;
	localparam logic [2:0] OP_STATUS_RD = 3'd3;
	localparam logic [2:0] OP_ADDR_WR = 3'd4;
	localparam logic [2:0] OP_DATA_RD = 3'd5;
	localparam logic [2:0] OP_DATA_WR = 3'd6;
	localparam logic [2:0] OP_SCROLL_WR = 3'd7;

	localparam logic [1:0] PH_PRE = 2'd0;
	localparam logic [1:0] PH_RENDER = 2'd1;
	localparam logic [1:0] PH_POST = 2'd2;
	localparam logic [1:0] PH_VBLANK = 2'd3;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] value;
		logic [7:0] bus_byte;
		logic       sprite_hit;
	} item_t;

	typedef struct packed {
		logic [14:0] cur_addr;
		logic [14:0] tmp_addr;
		logic [2:0]  fine_x;
		logic        first_write;
		logic [7:0]  read_buffer;
		logic        vblank_flag;
		logic        sprite_zero_flag;
		logic [4:0]  ctrl_bits;
		logic [3:0]  mask_bits;
		logic        even_frame;
		logic [1:0]  phase;
		logic [8:0]  dot;
		logic [8:0]  line;
	} state_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [14:0] vram_address;
		logic        vram_read;
		logic        vram_write;
		logic [7:0]  vram_write_data;
		logic        irq_pulse;
		logic [8:0]  dot_now;
		logic [8:0]  line_now;
		logic [2:0]  fine_x_out;
		logic [6:0]  render_controls;
	} result_t;

	localparam state_t STATE_RESET = '{
		cur_addr: 15'd0, tmp_addr: 15'd0, fine_x: 3'd0, first_write: 1'b1,
		read_buffer: 8'd0, vblank_flag: 1'b0, sprite_zero_flag: 1'b0,
		ctrl_bits: 5'd0, mask_bits: 4'd3, even_frame: 1'b1, phase: PH_PRE,
		dot: 9'd0, line: 9'd0
	};

	function automatic logic [14:0] increment_y(input logic [14:0] a);
		logic [14:0] r;
		logic [4:0]  cy;
		r = a;
		if (a[14:12] != 3'b111) begin
			r[14:12] = a[14:12] + 3'd1;
		end else begin
			r[14:12] = 3'b000;
			cy = a[9:5];
			if (cy == 5'd29) begin
				cy = 5'd0;
				r[11] = ~a[11];
			end else if (cy == 5'd31) begin
				cy = 5'd0;
			end else begin
				cy = cy + 5'd1;
			end
			r[9:5] = cy;
		end
		return r;
	endfunction

	function automatic logic [14:0] copy_bits(input logic [14:0] a, input logic [14:0] t,
		input logic [14:0] m);
		return (a & ~m) | (t & m);
	endfunction

endpackage

FILE: sv/vsrt_step.sv
// Next-state and result logic for one register access or dot tick.
module vsrt_step (
	input  vsrt_pkg::item_t   item,
	input  vsrt_pkg::state_t  st,
	output vsrt_pkg::state_t  ns,
	output vsrt_pkg::result_t res
);
	import vsrt_pkg::*;

	logic        ren;
	logic [8:0]  x;
	logic [14:0] next_addr;
	logic [2:0]  fx_sum;
	logic        irq;

	always_comb begin
		ns = st;
		irq = 1'b0;
		res = '0;
		res.vram_address = st.cur_addr;
		ren = (st.mask_bits[1:0] == 2'b11);
		x = st.dot - 9'd1;
		fx_sum = st.fine_x + x[2:0];
		next_addr = st.cur_addr + (st.ctrl_bits[0] ? 15'd32 : 15'd1);
		case (item.opcode)
			OP_TICK: begin
				case (st.phase)
					PH_PRE: begin
						if (st.dot == 9'd1) begin
							ns.vblank_flag = 1'b0;
							ns.sprite_zero_flag = 1'b0;
						end else if (st.dot == VISIBLE_DOTS + 9'd2 && ren) begin
							ns.cur_addr = copy_bits(st.cur_addr, st.tmp_addr, HCOPY_MASK);
						end else if (st.dot > VCOPY_FIRST_DOT && st.dot <= VCOPY_LAST_DOT
							&& ren) begin
							ns.cur_addr = copy_bits(st.cur_addr, st.tmp_addr, VCOPY_MASK);
						end
						if (st.dot >= LINE_END_DOT - {8'd0, (!st.even_frame && ren)}) begin
							ns.phase = PH_RENDER;
							ns.dot = 9'd0;
							ns.line = 9'd0;
						end
					end
					PH_RENDER: begin
						if (st.dot > 9'd0 && st.dot <= VISIBLE_DOTS) begin
							if (st.mask_bits[0] && fx_sum == 3'd7) begin
								if (st.cur_addr[4:0] == 5'd31) begin
									ns.cur_addr[4:0] = 5'd0;
									ns.cur_addr[10] = ~st.cur_addr[10];
								end else begin
									ns.cur_addr = st.cur_addr + 15'd1;
								end
							end
							if (item.sprite_hit && ren
								&& (!st.mask_bits[2] || x >= 9'd8)
								&& (!st.mask_bits[3] || x >= 9'd8)) begin
								ns.sprite_zero_flag = 1'b1;
							end
						end else if (st.dot == VISIBLE_DOTS + 9'd1 && st.mask_bits[0]) begin
							ns.cur_addr = increment_y(st.cur_addr);
						end else if (st.dot == VISIBLE_DOTS + 9'd2 && ren) begin
							ns.cur_addr = copy_bits(st.cur_addr, st.tmp_addr, HCOPY_MASK);
						end
						if (st.dot >= LINE_END_DOT) begin
							ns.line = st.line + 9'd1;
							ns.dot = 9'd0;
						end
						if (ns.line >= VISIBLE_LINES) begin
							ns.phase = PH_POST;
						end
					end
					PH_POST: begin
						if (st.dot >= LINE_END_DOT) begin
							ns.line = st.line + 9'd1;
							ns.dot = 9'd0;
							ns.phase = PH_VBLANK;
						end
					end
					default: begin
						if (st.dot == 9'd1 && st.line == VISIBLE_LINES + 9'd1) begin
							ns.vblank_flag = 1'b1;
							irq = st.ctrl_bits[4];
						end
						if (st.dot >= LINE_END_DOT) begin
							ns.line = st.line + 9'd1;
							ns.dot = 9'd0;
						end
						if (ns.line >= FRAME_END_LINE) begin
							ns.phase = PH_PRE;
							ns.line = 9'd0;
							ns.even_frame = ~st.even_frame;
						end
					end
				endcase
				ns.dot = ns.dot + 9'd1;
			end
			OP_CTRL_WR: begin
				ns.ctrl_bits = {item.value[7], item.value[5], item.value[4],
					item.value[3], item.value[2]};
				ns.tmp_addr[11:10] = item.value[1:0];
			end
			OP_MASK_WR: begin
				ns.mask_bits = {~item.value[2], ~item.value[1], item.value[4], item.value[3]};
			end
			OP_STATUS_RD: begin
				res.read_data = {st.vblank_flag, st.sprite_zero_flag, 6'd0};
				ns.vblank_flag = 1'b0;
				ns.first_write = 1'b1;
			end
			OP_ADDR_WR: begin
				if (st.first_write) begin
					ns.tmp_addr = {1'b0, item.value[5:0], st.tmp_addr[7:0]};
					ns.first_write = 1'b0;
				end else begin
					ns.tmp_addr = {st.tmp_addr[14:8], item.value};
					ns.cur_addr = {st.tmp_addr[14:8], item.value};
					ns.first_write = 1'b1;
				end
			end
			OP_DATA_RD: begin
				res.vram_read = 1'b1;
				ns.cur_addr = next_addr;
				if (next_addr < PALETTE_BASE) begin
					res.read_data = st.read_buffer;
					ns.read_buffer = item.bus_byte;
				end else begin
					res.read_data = item.bus_byte;
				end
			end
			OP_DATA_WR: begin
				res.vram_write = 1'b1;
				res.vram_write_data = item.value;
				ns.cur_addr = next_addr;
			end
			OP_SCROLL_WR: begin
				if (st.first_write) begin
					ns.tmp_addr[4:0] = item.value[7:3];
					ns.fine_x = item.value[2:0];
					ns.first_write = 1'b0;
				end else begin
					ns.tmp_addr[14:12] = item.value[2:0];
					ns.tmp_addr[9:5] = item.value[7:3];
					ns.first_write = 1'b1;
				end
			end
			default: begin
				ns = st;
			end
		endcase
		res.irq_pulse = irq;
		res.dot_now = ns.dot;
		res.line_now = ns.line;
		res.fine_x_out = ns.fine_x;
		res.render_controls = {ns.ctrl_bits[3], ns.ctrl_bits[1], ns.ctrl_bits[2],
			ns.mask_bits};
	end

endmodule

FILE: sv/video_scroll_register_timing_core.sv
// Top level of the video scroll register timing core: input register, state and result register.
// Throughput: one item per clock unless out_ready stalls the result register; the state update
// runs in the cycle an item leaves the input register, so the scroll address and counter loop
// through the step logic sets the rate.
// Reset: arst_n clears both pipeline stages and loads the power-up scroll and timing state.
module video_scroll_register_timing_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [7:0]  value,
	input  logic [7:0]  bus_byte,
	input  logic        sprite_hit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic [14:0] vram_address,
	output logic        vram_read,
	output logic        vram_write,
	output logic [7:0]  vram_write_data,
	output logic        irq_pulse,
	output logic [8:0]  dot_now,
	output logic [8:0]  line_now,
	output logic [2:0]  fine_x_out,
	output logic [6:0]  render_controls
);
	import vsrt_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  state_q;
	state_t  state_next;
	result_t res_next;
	logic    advance;

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{opcode: opcode, value: value, bus_byte: bus_byte,
				sprite_hit: sprite_hit};
		end
	end

	vsrt_step u_step (
		.item (item_s1),
		.st   (state_q),
		.ns   (state_next),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = valid_s2;
	assign read_data = res_s2.read_data;
	assign vram_address = res_s2.vram_address;
	assign vram_read = res_s2.vram_read;
	assign vram_write = res_s2.vram_write;
	assign vram_write_data = res_s2.vram_write_data;
	assign irq_pulse = res_s2.irq_pulse;
	assign dot_now = res_s2.dot_now;
	assign line_now = res_s2.line_now;
	assign fine_x_out = res_s2.fine_x_out;
	assign render_controls = res_s2.render_controls;

	a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.irq_pulse |-> !res_s2.vram_read && !res_s2.vram_write
			&& res_s2.read_data == 8'd0)
		else $error("interrupt raised on a register access");

	a_one_vram_access: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.vram_read && res_s2.vram_write))
		else $error("read and write strobes on the same item");

	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dot <= LINE_END_DOT + 9'd1 && state_q.line <= FRAME_END_LINE)
		else $error("dot or scanline counter out of range");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |=> valid_s1 && $stable(item_s1)
			&& $stable(state_q))
		else $error("input stage or state changed while the result was stalled");

endmodule

FILE: test/scroll_timing_checker.sv
// Checker for the video scroll register timing core: predicts every result and compares it.
`timescale 1ns / 1ps
module scroll_timing_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [7:0]  value,
	input  logic [7:0]  bus_byte,
	input  logic        sprite_hit,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  read_data,
	input  logic [14:0] vram_address,
	input  logic        vram_read,
	input  logic        vram_write,
	input  logic [7:0]  vram_write_data,
	input  logic        irq_pulse,
	input  logic [8:0]  dot_now,
	input  logic [8:0]  line_now,
	input  logic [2:0]  fine_x_out,
	input  logic [6:0]  render_controls,
	output int          mismatch_count,
	output int          results_pending
);
	import vsrt_pkg::*;

	state_t  core;
	result_t predicted_outputs[$];
	result_t want;
	result_t got;
	int      result_index;

	function automatic logic [14:0] next_row(input logic [14:0] a);
		logic [14:0] r;
		logic [4:0]  row;
		r = a;
		if (a[14:12] != 3'd7) begin
			r[14:12] = a[14:12] + 3'd1;
		end else begin
			r[14:12] = 3'd0;
			row = a[9:5];
			case (row)
				5'd29: begin
					row = 5'd0;
					r[11] = ~a[11];
				end
				5'd31: row = 5'd0;
				default: row = row + 5'd1;
			endcase
			r[9:5] = row;
		end
		return r;
	endfunction

	function automatic logic dot_tick(input logic hit);
		logic       irq;
		logic       ren;
		logic [8:0] x;
		logic [2:0] col;
		irq = 1'b0;
		ren = core.mask_bits[1:0] == 2'b11;
		case (core.phase)
			PH_PRE: begin
				if (core.dot == 9'd1) begin
					core.vblank_flag = 1'b0;
					core.sprite_zero_flag = 1'b0;
				end else if (core.dot == VISIBLE_DOTS + 9'd2 && ren) begin
					core.cur_addr = (core.cur_addr & ~HCOPY_MASK) | (core.tmp_addr & HCOPY_MASK);
				end else if (core.dot > VCOPY_FIRST_DOT && core.dot <= VCOPY_LAST_DOT && ren) begin
					core.cur_addr = (core.cur_addr & ~VCOPY_MASK) | (core.tmp_addr & VCOPY_MASK);
				end
				if (core.dot >= LINE_END_DOT - {8'd0, ~core.even_frame & ren}) begin
					core.phase = PH_RENDER;
					core.dot = 9'd0;
					core.line = 9'd0;
				end
			end
			PH_RENDER: begin
				if (core.dot != 9'd0 && core.dot <= VISIBLE_DOTS) begin
					x = core.dot - 9'd1;
					col = core.fine_x + x[2:0];
					if (core.mask_bits[0] && col == 3'd7) begin
						if (core.cur_addr[4:0] == 5'd31) begin
							core.cur_addr[4:0] = 5'd0;
							core.cur_addr[10] = ~core.cur_addr[10];
						end else begin
							core.cur_addr = core.cur_addr + 15'd1;
						end
					end
					if (hit && ren && (!core.mask_bits[2] || x >= 9'd8)
						&& (!core.mask_bits[3] || x >= 9'd8)) begin
						core.sprite_zero_flag = 1'b1;
					end
				end else if (core.dot == VISIBLE_DOTS + 9'd1 && core.mask_bits[0]) begin
					core.cur_addr = next_row(core.cur_addr);
				end else if (core.dot == VISIBLE_DOTS + 9'd2 && ren) begin
					core.cur_addr = (core.cur_addr & ~HCOPY_MASK) | (core.tmp_addr & HCOPY_MASK);
				end
				if (core.dot >= LINE_END_DOT) begin
					core.line = core.line + 9'd1;
					core.dot = 9'd0;
				end
				if (core.line >= VISIBLE_LINES) begin
					core.phase = PH_POST;
				end
			end
			PH_POST: begin
				if (core.dot >= LINE_END_DOT) begin
					core.line = core.line + 9'd1;
					core.dot = 9'd0;
					core.phase = PH_VBLANK;
				end
			end
			default: begin
				if (core.dot == 9'd1 && core.line == VISIBLE_LINES + 9'd1) begin
					core.vblank_flag = 1'b1;
					irq = core.ctrl_bits[4];
				end
				if (core.dot >= LINE_END_DOT) begin
					core.line = core.line + 9'd1;
					core.dot = 9'd0;
				end
				if (core.line >= FRAME_END_LINE) begin
					core.phase = PH_PRE;
					core.line = 9'd0;
					core.even_frame = ~core.even_frame;
				end
			end
		endcase
		core.dot = core.dot + 9'd1;
		return irq;
	endfunction

	function automatic result_t scroll_step(input logic [2:0] op, input logic [7:0] v,
		input logic [7:0] bus, input logic hit);
		result_t r;
		r = '0;
		r.vram_address = core.cur_addr;
		case (op)
			OP_TICK: r.irq_pulse = dot_tick(hit);
			OP_CTRL_WR: begin
				core.ctrl_bits = {v[7], v[5], v[4], v[3], v[2]};
				core.tmp_addr[11:10] = v[1:0];
			end
			OP_MASK_WR: core.mask_bits = {~v[2], ~v[1], v[4], v[3]};
			OP_STATUS_RD: begin
				r.read_data = {core.vblank_flag, core.sprite_zero_flag, 6'd0};
				core.vblank_flag = 1'b0;
				core.first_write = 1'b1;
			end
			OP_ADDR_WR: begin
				if (core.first_write) begin
					core.tmp_addr[14:8] = {1'b0, v[5:0]};
				end else begin
					core.tmp_addr[7:0] = v;
					core.cur_addr = core.tmp_addr;
				end
				core.first_write = ~core.first_write;
			end
			OP_DATA_RD: begin
				r.vram_read = 1'b1;
				core.cur_addr = core.cur_addr + (core.ctrl_bits[0] ? 15'd32 : 15'd1);
				if (core.cur_addr < PALETTE_BASE) begin
					r.read_data = core.read_buffer;
					core.read_buffer = bus;
				end else begin
					r.read_data = bus;
				end
			end
			OP_DATA_WR: begin
				r.vram_write = 1'b1;
				r.vram_write_data = v;
				core.cur_addr = core.cur_addr + (core.ctrl_bits[0] ? 15'd32 : 15'd1);
			end
			default: begin
				if (core.first_write) begin
					core.tmp_addr[4:0] = v[7:3];
					core.fine_x = v[2:0];
				end else begin
					core.tmp_addr[14:12] = v[2:0];
					core.tmp_addr[9:5] = v[7:3];
				end
				core.first_write = ~core.first_write;
			end
		endcase
		r.dot_now = core.dot;
		r.line_now = core.line;
		r.fine_x_out = core.fine_x;
		r.render_controls = {core.ctrl_bits[3], core.ctrl_bits[1], core.ctrl_bits[2],
			core.mask_bits};
		return r;
	endfunction

	function automatic string show(input result_t r);
		string head;
		head = $sformatf("rd=%h addr=%h rd_en=%b wr_en=%b wr_data=%h",
			r.read_data, r.vram_address, r.vram_read, r.vram_write, r.vram_write_data);
		return {head, $sformatf(" irq=%b dot=%0d line=%0d fine_x=%0d ctl=%h",
			r.irq_pulse, r.dot_now, r.line_now, r.fine_x_out, r.render_controls)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core = '0;
			core.first_write = 1'b1;
			core.mask_bits = 4'b0011;
			core.even_frame = 1'b1;
			core.phase = PH_PRE;
			predicted_outputs.delete();
			mismatch_count = 0;
			results_pending = 0;
			result_index = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {read_data, vram_address, vram_read, vram_write, vram_write_data,
					irq_pulse, dot_now, line_now, fine_x_out, render_controls};
				if (predicted_outputs.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("result %0d arrived with nothing expected: %s", result_index,
							show(got));
					end
					mismatch_count++;
				end else begin
					want = predicted_outputs.pop_front();
					if (got !== want) begin
						if (mismatch_count < 10) begin
							$display("result %0d mismatch", result_index);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
						mismatch_count++;
					end
				end
				result_index++;
			end
			if (in_valid && in_ready) begin
				predicted_outputs.insert(predicted_outputs.size(),
					scroll_step(opcode, value, bus_byte, sprite_hit));
			end
			results_pending = predicted_outputs.size();
		end
	end

endmodule

FILE: test/video_scroll_register_timing_core_test.sv
// Testbench top for the video scroll register timing core: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module video_scroll_register_timing_core_test;
	import vsrt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int PHASE_ITEMS = 35;
	localparam int SWEEP_ITEMS = 20;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = OP_TICK;
	logic [7:0]  value = 8'd0;
	logic [7:0]  bus_byte = 8'd0;
	logic        sprite_hit = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  read_data;
	logic [14:0] vram_address;
	logic        vram_read;
	logic        vram_write;
	logic [7:0]  vram_write_data;
	logic        irq_pulse;
	logic [8:0]  dot_now;
	logic [8:0]  line_now;
	logic [2:0]  fine_x_out;
	logic [6:0]  render_controls;
	int          mismatch_count;
	int          results_pending;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          items_sent = 0;
	int unsigned cycle_count = 0;
	logic        long_hold_req = 1'b0;

	video_scroll_register_timing_core uut (.*);

	scroll_timing_checker timing_check (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("video_scroll_register_timing_core_test: errors");
			$finish;
		end
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic drive_item(input logic [2:0] op, input logic [7:0] v, input logic [7:0] bus,
		input logic hit);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		value <= v;
		bus_byte <= bus;
		sprite_hit <= hit;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic run_ticks(input int n);
		repeat (n) drive_item(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	function automatic logic [7:0] mask_value();
		logic [7:0] v;
		v = 8'($urandom);
		if ($urandom_range(7) != 0) begin
			v[4:3] = 2'b11;
		end
		return v;
	endfunction

	task automatic random_sequence();
		int         kind;
		logic [7:0] hi;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2: run_ticks($urandom_range(1, 40));
			3: begin
				case ($urandom_range(3))
					0: hi = 8'h3f;
					1: hi = 8'h3e;
					default: hi = 8'($urandom);
				endcase
				if ($urandom_range(1) == 0) begin
					drive_item(OP_STATUS_RD, 8'($urandom), 8'($urandom), 1'($urandom));
				end
				drive_item(OP_ADDR_WR, hi, 8'($urandom), 1'($urandom));
				drive_item(OP_ADDR_WR, 8'($urandom), 8'($urandom), 1'($urandom));
				repeat ($urandom_range(1, 4)) begin
					drive_item($urandom_range(1) ? OP_DATA_RD : OP_DATA_WR, 8'($urandom),
						8'($urandom), 1'($urandom));
				end
			end
			4: begin
				drive_item(OP_SCROLL_WR, 8'($urandom), 8'($urandom), 1'($urandom));
				drive_item(OP_SCROLL_WR, 8'($urandom), 8'($urandom), 1'($urandom));
			end
			5: drive_item(OP_CTRL_WR, 8'($urandom), 8'($urandom), 1'($urandom));
			6: drive_item(OP_MASK_WR, mask_value(), 8'($urandom), 1'($urandom));
			7: drive_item(OP_STATUS_RD, 8'($urandom), 8'($urandom), 1'($urandom));
			8: drive_item(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
			default: begin
				drive_item($urandom_range(1) ? OP_ADDR_WR : OP_SCROLL_WR, 8'($urandom),
					8'($urandom), 1'($urandom));
				drive_item(OP_STATUS_RD, 8'($urandom), 8'($urandom), 1'($urandom));
			end
		endcase
	endtask

	task automatic random_phase(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) random_sequence();
	endtask

	// Tick runs with rendering on and the interrupt enabled, with sparse register accesses.
	task automatic frame_sweep(input int n);
		logic [2:0] op;
		logic [7:0] v;
		drive_item(OP_MASK_WR, 8'h1e, 8'($urandom), 1'($urandom));
		drive_item(OP_CTRL_WR, 8'h80 | 8'($urandom), 8'($urandom), 1'($urandom));
		repeat (n) begin
			if ($urandom_range(199) == 0) begin
				op = 3'($urandom_range(1, 7));
				v = (op == OP_MASK_WR) ? mask_value() : 8'($urandom);
				drive_item(op, v, 8'($urandom), 1'($urandom));
			end else begin
				drive_item(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drive_item(OP_STATUS_RD, 8'h00, 8'h00, 1'b0);
		drive_item(OP_SCROLL_WR, 8'hff, 8'hff, 1'b1);
		drive_item(OP_SCROLL_WR, 8'hff, 8'h00, 1'b0);
		drive_item(OP_CTRL_WR, 8'hff, 8'h00, 1'b0);
		// The pre-render line copies the all-ones temporary address into the current one.
		run_ticks(310);
		drive_item(OP_DATA_WR, 8'hff, 8'h00, 1'b0);
		drive_item(OP_DATA_RD, 8'h00, 8'hff, 1'b1);
		drive_item(OP_CTRL_WR, 8'h00, 8'h00, 1'b0);
		drive_item(OP_MASK_WR, 8'h00, 8'h00, 1'b0);
		drive_item(OP_MASK_WR, 8'hff, 8'h00, 1'b0);
		drive_item(OP_MASK_WR, 8'h18, 8'h00, 1'b0);
		drive_item(OP_ADDR_WR, 8'hff, 8'h00, 1'b0);
		drive_item(OP_ADDR_WR, 8'h00, 8'h00, 1'b0);
		drive_item(OP_DATA_RD, 8'h00, 8'h3c, 1'b0);
		drive_item(OP_ADDR_WR, 8'h3e, 8'h00, 1'b0);
		drive_item(OP_ADDR_WR, 8'hfe, 8'h00, 1'b0);
		drive_item(OP_DATA_RD, 8'h00, 8'ha5, 1'b0);
		drive_item(OP_DATA_RD, 8'h00, 8'h5a, 1'b0);
		drive_item(OP_DATA_WR, 8'h00, 8'h00, 1'b0);
		drive_item(OP_ADDR_WR, 8'h12, 8'h00, 1'b0);
		drive_item(OP_STATUS_RD, 8'h00, 8'h00, 1'b0);
		drive_item(OP_ADDR_WR, 8'h3f, 8'h00, 1'b0);
		drive_item(OP_ADDR_WR, 8'h80, 8'h00, 1'b0);
		drive_item(OP_SCROLL_WR, 8'h00, 8'h00, 1'b0);
		drive_item(OP_SCROLL_WR, 8'h00, 8'h00, 1'b0);
		drive_item(OP_MASK_WR, 8'h1e, 8'h00, 1'b0);

		random_phase(PHASE_ITEMS);

		send_idle_pct = 83;
		random_phase(PHASE_ITEMS);

		send_idle_pct = 0;
		recv_stall_pct = 83;
		long_hold_req = 1'b1;
		run_ticks(40);
		random_phase(PHASE_ITEMS);

		send_idle_pct = 14;
		recv_stall_pct = 14;
		random_phase(PHASE_ITEMS);
		frame_sweep(SWEEP_ITEMS);

		in_valid <= 1'b0;
		recv_stall_pct = 0;
		do @(negedge clk); while (results_pending != 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0) begin
			$display("video_scroll_register_timing_core_test: clean");
		end else begin
			$display("video_scroll_register_timing_core_test: errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/vsrt_pkg.sv
sv/vsrt_step.sv
sv/video_scroll_register_timing_core.sv
test/scroll_timing_checker.sv
test/video_scroll_register_timing_core_test.sv
